@@ hw/rtl/vpa_pkg.sv @@
// Shared types and constants of the vocabulary projection argmax block.
`default_nettype none

package vpa_pkg;

    // Field widths
    localparam int ELEM_W     = 16;
    localparam int SCORE_W    = 48;
    localparam int INDEX_W    = 18;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int VLEN_W     = 13;
    localparam int ROWS_W     = 19;
    localparam int CFG_DATA_W = 19;

    // Register reset values
    localparam logic [VLEN_W-1:0]  VLEN_RESET = 13'd1024;
    localparam logic [ROWS_W-1:0]  ROWS_RESET = 19'd65536;

    // Most negative 48-bit score, start value of the running best
    localparam logic [SCORE_W-1:0] SCORE_MOST_NEG = {1'b1, {(SCORE_W-1){1'b0}}};

    // Request kinds
    typedef enum logic {
        REQ_QUERY = 1'b0,
        REQ_TABLE = 1'b1
    } t_req_kind;

    // Configuration register indexes
    typedef enum logic {
        CFG_VECTOR_LENGTH = 1'b0,
        CFG_ROW_TOTAL     = 1'b1
    } t_cfg_idx;

    // Input request payload
    typedef struct packed {
        t_req_kind          req_type;
        logic [ELEM_W-1:0]  elem_value;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [INDEX_W-1:0] best_index;
        logic [SCORE_W-1:0] best_score;
    } t_res;

    // Configuration write payload
    typedef struct packed {
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/vpa_stream_if.sv @@
// Valid/ready channel carrying one payload type.
`default_nettype none

interface vpa_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/vocab_projection_argmax.sv @@
// Top level: query-vector dot product against streamed table rows, keeps the best row.
//
// Channels:
//   i_in  : requests. req_type REQ_QUERY writes the next query element into the
//           vector store, REQ_TABLE supplies the next table element (row-major).
//   o_res : one result per pass (after row_total rows): best row index and score.
//   i_cfg : register writes (vector_length, row_total); always ready, to be used
//           only while no request is in flight.
// Throughput: one request per cycle unless stalled. Each table element takes
//   one read of the vector store, one 16x16 multiply and one 48-bit add; these
//   sit in separate pipeline stages, so the rate is set by the single store read port.
// Result path: the last table element of a pass goes through the store read,
//   multiply, accumulate and compare stages before the result shows on o_res.
// Reset: counters clear, best score goes to the most negative value and the
//   registers take vector_length 1024, row_total 65536. The vector store is not
//   cleared; it must be loaded before table elements arrive.
// Receiver stall: requests keep flowing while a result waits on o_res. Only
//   when the next pass result reaches the compare stage with the previous one
//   still unread does i_in.ready drop until o_res is taken.
`default_nettype none

module vocab_projection_argmax
    import vpa_pkg::*;
#(
    parameter int MAX_VECTOR = 4096,
    parameter int MAX_ROWS   = 262144
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    vpa_stream_if.sink      i_in,
    vpa_stream_if.source    o_res,
    vpa_stream_if.sink      i_cfg
);

    localparam int AW  = $clog2(MAX_VECTOR);      // vector store address
    localparam int CW  = $clog2(MAX_VECTOR + 1);  // column / fill counters
    localparam int RW  = $clog2(MAX_ROWS);        // row index
    localparam int RCW = $clog2(MAX_ROWS + 1);    // row count compare

    // Configuration registers
    logic [VLEN_W-1:0] r_vlen;
    logic [ROWS_W-1:0] r_rows;

    // Vector store
    logic [ELEM_W-1:0] mem [MAX_VECTOR];

    // Front-end counters
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // Stage 1: store read data and element
    logic                     r_v1;
    logic                     r_end1, r_last1;
    logic [RW-1:0]            r_row1;
    logic signed [ELEM_W-1:0] r_q1, r_e1;

    // Stage 2: product
    logic                     r_v2;
    logic                     r_end2, r_last2;
    logic [RW-1:0]            r_row2;
    logic signed [PROD_W-1:0] r_prod2;

    // Accumulator and finished row sum
    logic [SCORE_W-1:0] r_row_sum;
    logic [SCORE_W-1:0] acc_sum;
    logic               r_fin_v, r_fin_last;
    logic [RW-1:0]      r_fin_row;
    logic [SCORE_W-1:0] r_fin_sum;

    // Running best and output register
    logic [SCORE_W-1:0] r_top_score, n_win_score;
    logic [RW-1:0]      r_top_row, n_win_row;
    logic               r_out_valid;
    t_res               r_out;

    // Control
    logic          stall;
    logic          in_acc;
    logic          is_table;
    logic [CW-1:0] eff_len;
    logic [RCW-1:0] eff_rows;
    logic [CW-1:0] fill_base, fill_inc, col_inc;
    logic [RCW-1:0] row_inc;
    logic          end_row, last_row;

    // Hold the pipe only when a pass result would land on an unread result
    assign stall    = r_fin_v && r_fin_last && r_out_valid;
    assign i_in.ready  = !stall;
    assign i_cfg.ready = 1'b1;
    assign in_acc   = i_in.valid && !stall;
    assign is_table = (i_in.payload.req_type == REQ_TABLE);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= VLEN_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                CFG_VECTOR_LENGTH: r_vlen <= i_cfg.payload.data[VLEN_W-1:0];
                CFG_ROW_TOTAL:     r_rows <= i_cfg.payload.data[ROWS_W-1:0];
                default:           r_vlen <= r_vlen;
            endcase
        end
    end

    // Effective lengths: zero acts as one, clamp at the store / row limits
    always_comb begin
        if (r_vlen == '0) begin
            eff_len = CW'(1);
        end else if (int'(r_vlen) > MAX_VECTOR) begin
            eff_len = CW'(MAX_VECTOR);
        end else begin
            eff_len = CW'(r_vlen);
        end
        if (r_rows == '0) begin
            eff_rows = RCW'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(r_rows);
        end
    end

    // Counter updates for the request being accepted
    always_comb begin
        fill_base = (r_fill >= eff_len) ? '0 : r_fill;
        fill_inc  = fill_base + CW'(1);
        col_inc   = r_col + CW'(1);
        row_inc   = RCW'(r_row) + RCW'(1);
        end_row   = (col_inc >= eff_len);
        last_row  = end_row && (row_inc >= eff_rows);

        n_fill = r_fill;
        n_col  = r_col;
        n_row  = r_row;
        if (is_table) begin
            n_col = end_row ? '0 : col_inc;
            if (end_row) begin
                n_row = last_row ? '0 : row_inc[RW-1:0];
            end
        end else begin
            n_fill = (fill_inc >= eff_len) ? '0 : fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (in_acc) begin
            r_fill <= n_fill;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

    // Vector store: write on query load, registered read on table element
    always_ff @(posedge i_clk) begin
        if (in_acc && !is_table) begin
            mem[fill_base[AW-1:0]] <= i_in.payload.elem_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_table) begin
            r_q1 <= mem[r_col[AW-1:0]];
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_e1    <= i_in.payload.elem_value;
            r_end1  <= end_row;
            r_last1 <= last_row;
            r_row1  <= r_row;
        end
    end

    // Stage 2: multiply
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_prod2 <= r_q1 * r_e1;
            r_end2  <= r_end1;
            r_last2 <= r_last1;
            r_row2  <= r_row1;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (!stall) begin
            r_v1 <= in_acc && is_table;
            r_v2 <= r_v1;
        end
    end

    // Stage 3: accumulate, hand a finished row to the compare stage
    assign acc_sum = r_row_sum + SCORE_W'(r_prod2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
            r_fin_v   <= 1'b0;
        end else if (!stall) begin
            r_fin_v <= r_v2 && r_end2;
            if (r_v2) begin
                r_row_sum <= r_end2 ? '0 : acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_fin_sum  <= acc_sum;
            r_fin_row  <= r_row2;
            r_fin_last <= r_last2;
        end
    end

    // Stage 4: strict greater-than keeps the earliest row on ties
    always_comb begin
        n_win_score = r_top_score;
        n_win_row   = r_top_row;
        if ($signed(r_fin_sum) > $signed(r_top_score)) begin
            n_win_score = r_fin_sum;
            n_win_row   = r_fin_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_score <= SCORE_MOST_NEG;
            r_top_row   <= '0;
        end else if (r_fin_v && !stall) begin
            if (r_fin_last) begin
                r_top_score <= SCORE_MOST_NEG;
                r_top_row   <= '0;
            end else begin
                r_top_score <= n_win_score;
                r_top_row   <= n_win_row;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_fin_v && r_fin_last && !stall) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin_v && r_fin_last && !stall) begin
            r_out.best_index <= INDEX_W'(n_win_row);
            r_out.best_score <= n_win_score;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // Checks
    a_pass_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_v && r_fin_last && !r_out_valid |=> r_out_valid)
        else $error("pass result not registered");

    a_best_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_top_score == SCORE_MOST_NEG && r_top_row == '0)
        else $error("running best not cleared after pass");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < MAX_VECTOR && int'(r_fill) < MAX_VECTOR)
        else $error("vector counter beyond store depth");

    a_stall_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> !r_v1 || $stable(r_q1))
        else $error("store read moved during stall");

endmodule

`default_nettype wire

@@ test/tb_vocab_projection_argmax.sv @@
// Testbench for vocab_projection_argmax: dot-product row argmax checked against a local predictor.
`timescale 1ns / 100ps

module tb_vocab_projection_argmax;
    import vpa_pkg::*;

    localparam int MAX_VECTOR     = 4096;
    localparam int MAX_ROWS       = 262144;
    localparam int CLK_HALF       = 5;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_REQUESTS = 250;

    // Predicts the winning row of each pass and checks the results against it
    class row_argmax_model;
        logic [ELEM_W-1:0]         query_mem [MAX_VECTOR];
        logic [VLEN_W-1:0]         vlen_reg;
        logic [ROWS_W-1:0]         rows_reg;
        int unsigned               fill;
        int unsigned               col;
        int unsigned               row;
        logic signed [SCORE_W-1:0] row_acc;
        logic signed [SCORE_W-1:0] top_score;
        logic [INDEX_W-1:0]        top_row;
        t_res                      pending_winners[$];
        int unsigned               mismatches;
        int unsigned               winners_seen;

        function new();
            vlen_reg     = VLEN_RESET;
            rows_reg     = ROWS_RESET;
            fill         = 0;
            col          = 0;
            row          = 0;
            row_acc      = '0;
            top_score    = SCORE_MOST_NEG;
            top_row      = '0;
            mismatches   = 0;
            winners_seen = 0;
        endfunction

        function int unsigned eff_len();
            if (vlen_reg == 0) return 1;
            if (vlen_reg > MAX_VECTOR) return MAX_VECTOR;
            return 32'(vlen_reg);
        endfunction

        function int unsigned eff_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return 32'(rows_reg);
        endfunction

        function void apply_write(t_cfg w);
            if (w.index == CFG_VECTOR_LENGTH) begin
                vlen_reg = w.data[VLEN_W-1:0];
            end else begin
                rows_reg = w.data[ROWS_W-1:0];
            end
        endfunction

        function void take_request(t_req r);
            int unsigned              len;
            logic signed [PROD_W-1:0] prod;
            t_res                     win;
            len = eff_len();
            // query load: fill wraps, stale fill restarts at 0
            if (r.req_type == REQ_QUERY) begin
                if (fill >= len) fill = 0;
                query_mem[fill] = r.elem_value;
                fill++;
                if (fill >= len) fill = 0;
                return;
            end
            // table element: exact product into the row sum
            prod    = $signed(query_mem[col]) * $signed(r.elem_value);
            row_acc = row_acc + prod;
            col++;
            if (col < len) return;
            // row end: strictly greater wins, so ties keep the earlier row
            col = 0;
            if (row_acc > top_score) begin
                top_score = row_acc;
                top_row   = row[INDEX_W-1:0];
            end
            row_acc = '0;
            row++;
            if (row < eff_rows()) return;
            win.best_index  = top_row;
            win.best_score  = top_score;
            pending_winners = {pending_winners, win};
            row       = 0;
            top_row   = '0;
            top_score = SCORE_MOST_NEG;
        endfunction

        function void check_winner(t_res got);
            t_res want;
            if (pending_winners.size() == 0) begin
                $error("unexpected result: best_index %0d best_score %0d",
                       got.best_index, $signed(got.best_score));
                mismatches++;
                return;
            end
            want = pending_winners.pop_front();
            winners_seen++;
            if (got.best_index !== want.best_index) begin
                $error("best_index mismatch: expected %0d, actual %0d",
                       want.best_index, got.best_index);
                mismatches++;
            end
            if (got.best_score !== want.best_score) begin
                $error("best_score mismatch: expected %0d, actual %0d",
                       $signed(want.best_score), $signed(got.best_score));
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    vpa_stream_if #(.T(t_req)) req_ch ();
    vpa_stream_if #(.T(t_res)) win_ch ();
    vpa_stream_if #(.T(t_cfg)) cfg_ch ();

    vocab_projection_argmax #(
        .MAX_VECTOR (MAX_VECTOR),
        .MAX_ROWS   (MAX_ROWS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_res   (win_ch),
        .i_cfg   (cfg_ch)
    );

    row_argmax_model sb = new();

    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int unsigned requests_sent = 0;
    int unsigned cfg_writes    = 0;
    int unsigned quiet_cycles  = 0;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Result side backpressure
    always @(negedge i_clk) begin
        win_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Observe every handshake; results are checked before new requests are noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (win_ch.valid && win_ch.ready) sb.check_winner(win_ch.payload);
            if (cfg_ch.valid && cfg_ch.ready) sb.apply_write(cfg_ch.payload);
            if (req_ch.valid && req_ch.ready) sb.take_request(req_ch.payload);
            if ((win_ch.valid && win_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (req_ch.valid && req_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // Watchdog: too long without any handshake
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [ELEM_W-1:0] rand_elem();
        if ($urandom_range(9) != 0) return ELEM_W'($urandom);
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // All tasks start and end at a falling edge
    task automatic send_req(input t_req_kind kind, input logic [ELEM_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= t_req'{req_type: kind, elem_value: value};
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= t_cfg'{index: idx, data: value};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        cfg_writes++;
    endtask

    // Sender holds until every winner is out, then lets the pipeline drain
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.pending_winners.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_query(input int unsigned count);
        repeat (count) send_req(REQ_QUERY, rand_elem());
    endtask

    // One full pass; some rows repeat the previous one to force ties,
    // and a query element is occasionally rewritten mid-pass
    task automatic run_pass();
        int unsigned       len;
        int unsigned       rows;
        bit                replay;
        logic [ELEM_W-1:0] v;
        logic [ELEM_W-1:0] prev_row[$];
        logic [ELEM_W-1:0] this_row[$];
        len  = sb.eff_len();
        rows = sb.eff_rows();
        for (int unsigned r = 0; r < rows; r++) begin
            replay = (r != 0) && ($urandom_range(4) == 0);
            this_row.delete();
            for (int unsigned c = 0; c < len; c++) begin
                v = replay ? prev_row[c] : rand_elem();
                if ($urandom_range(39) == 0) send_req(REQ_QUERY, rand_elem());
                send_req(REQ_TABLE, v);
                this_row = {this_row, v};
            end
            prev_row = this_row;
        end
    endtask

    initial begin
        int unsigned             phase_start;
        logic [CFG_DATA_W-1:0]   vl_pick;
        logic [CFG_DATA_W-1:0]   rt_pick;

        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        win_ch.ready   = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extreme elements, very negative first row, tie on rows 1 and 2
        write_reg(CFG_VECTOR_LENGTH, CFG_DATA_W'(4));
        write_reg(CFG_ROW_TOTAL, CFG_DATA_W'(3));
        send_req(REQ_QUERY, 16'h7FFF);
        send_req(REQ_QUERY, 16'h8000);
        send_req(REQ_QUERY, 16'h0001);
        send_req(REQ_QUERY, 16'hFFFF);
        send_req(REQ_TABLE, 16'h8000);
        send_req(REQ_TABLE, 16'h7FFF);
        send_req(REQ_TABLE, 16'h8000);
        send_req(REQ_TABLE, 16'h7FFF);
        repeat (2) begin
            send_req(REQ_TABLE, 16'h7FFF);
            send_req(REQ_TABLE, 16'h8000);
            send_req(REQ_TABLE, 16'h0000);
            send_req(REQ_TABLE, 16'h0000);
        end
        // Partial reload over the old query, then stop mid-row
        send_req(REQ_QUERY, 16'h0001);
        send_req(REQ_QUERY, 16'h0002);
        send_req(REQ_TABLE, 16'h7FFF);
        send_req(REQ_TABLE, 16'h7FFF);
        settle();
        // Shrink the vector length to the column count, row total to one: next element ends row and pass
        write_reg(CFG_VECTOR_LENGTH, CFG_DATA_W'(2));
        write_reg(CFG_ROW_TOTAL, CFG_DATA_W'(1));
        send_req(REQ_TABLE, 16'h8000);
        send_req(REQ_QUERY, 16'h8000);
        settle();
        // Zero lengths act as one
        write_reg(CFG_VECTOR_LENGTH, '0);
        write_reg(CFG_ROW_TOTAL, '0);
        send_req(REQ_QUERY, 16'h7FFF);
        send_req(REQ_TABLE, 16'h7FFF);
        send_req(REQ_TABLE, 16'h8000);

        // Random passes under four pacing mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 45;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 45;
                end
                default: begin
                    src_idle_pct  = 28;
                    snk_stall_pct = 28;
                end
            endcase
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS) begin
                settle();
                case ($urandom_range(9))
                    0:       vl_pick = '0;
                    1:       vl_pick = CFG_DATA_W'(1);
                    2:       vl_pick = CFG_DATA_W'($urandom_range(17, 48));
                    default: vl_pick = CFG_DATA_W'($urandom_range(2, 12));
                endcase
                case ($urandom_range(9))
                    0:       rt_pick = '0;
                    1:       rt_pick = CFG_DATA_W'(1);
                    2:       rt_pick = CFG_DATA_W'($urandom_range(7, 12));
                    default: rt_pick = CFG_DATA_W'($urandom_range(2, 6));
                endcase
                if ($urandom_range(1) == 0) begin
                    write_reg(CFG_VECTOR_LENGTH, vl_pick);
                    write_reg(CFG_ROW_TOTAL, rt_pick);
                end else begin
                    write_reg(CFG_ROW_TOTAL, rt_pick);
                    write_reg(CFG_VECTOR_LENGTH, vl_pick);
                end
                load_query(sb.eff_len());
                run_pass();
                // Back-to-back pass with a partial reload; sometimes pause for all winners
                if ($urandom_range(2) == 0) begin
                    if ($urandom_range(1) == 0) settle();
                    load_query($urandom_range(1, sb.eff_len()));
                    run_pass();
                end
            end
        end
        settle();

        $display("Checked %0d winners from %0d requests and %0d register writes",
                 sb.winners_seen, requests_sent, cfg_writes);
        $display("Rows of 1 to 48 elements, passes of 1 to 12 rows, four pacing mixes");
        if (sb.mismatches == 0 && sb.pending_winners.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
